@@ sv/jbhd_pkg.sv @@
// Shared types and constants of the block Huffman decoder.
`default_nettype none
package jbhd_pkg;
  localparam int TableEntries = 16;
  localparam int SlotBits = 4;
  localparam int MaxCodeBits = 16;
  // one memory word: code, length, symbol
  localparam int EntryBits = 16 + 5 + 8;
  // DC and AC tables share one memory, table bit above the slot
  localparam int MemDepth = 2 * TableEntries;
  localparam int MemAddrBits = SlotBits + 1;

  localparam logic [1:0] KindLoadDc = 2'd0;
  localparam logic [1:0] KindLoadAc = 2'd1;
  localparam logic [1:0] KindBit = 2'd2;
  localparam logic [1:0] KindUnused = 2'd3;

  localparam logic RegDcUsed = 1'b0;
  localparam logic RegAcUsed = 1'b1;

  typedef struct packed {
    logic [15:0] code;
    logic [4:0]  length;
    logic [7:0]  symbol;
  } entry_t;
endpackage
`default_nettype wire

@@ sv/jpeg_block_huffman_decoder.sv @@
// Top level of the JPEG baseline block Huffman decoder.
// Input channel (valid/ready): kind selects a DC or AC table load or one
// stream bit. Load beats write the table memory when accepted. A stream
// bit in a code phase walks the active table one entry at a time (read,
// then compare) through the table memory; magnitude bits are taken in
// the idle state without a table access. Each result beat (coefficient
// position, value, block_last, code_error) is loaded into the output
// register in S_EMIT and handed over in S_WAIT. EOB emits up to 63
// beats from one item, a zero run up to 16.
// Output channel is a single register: when the receiver stalls, emission
// holds and no further input is taken until the item's results are out.
// Registers are written on cfg write enable: index 0 DC entries used,
// index 1 AC entries used; values above 16 act as 16.
// Reset (rst, synchronous) clears the decode state and the entry counts;
// table contents stay undefined until loaded. No clearing pass is needed.
`default_nettype none
module jpeg_block_huffman_decoder (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [4:0]        cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        kind,
  input  wire logic [3:0]        entry_slot,
  input  wire logic [15:0]       entry_code,
  input  wire logic [4:0]        entry_length,
  input  wire logic [7:0]        entry_symbol,
  input  wire logic              bit_value,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [5:0]             coeff_position,
  output logic signed [11:0]     coeff_value,
  output logic                   block_last,
  output logic                   code_error
);
  typedef enum logic [2:0] {S_IDLE, S_READ, S_CHECK, S_EMIT, S_WAIT} state_t;
  typedef enum logic [1:0] {PH_DC, PH_AC, PH_MAG} phase_t;
  // what the emit loop does once the pending zeros are out
  typedef enum logic [1:0] {E_COEF, E_EOB, E_ONE} emit_t;

  state_t state;
  phase_t phase;
  emit_t  emode;
  logic [4:0]  dc_used, ac_used, lim;
  logic [15:0] code_bits;
  logic [4:0]  code_count;
  logic [3:0]  mag_left, cur_mag;
  logic [10:0] value_bits;
  logic [3:0]  run;
  logic [5:0]  pos;
  logic signed [11:0] pend_val;
  logic [4:0]  idx;
  logic [jbhd_pkg::MemAddrBits-1:0] raddr;
  jbhd_pkg::entry_t rentry, wentry;
  logic we;
  logic [3:0] mag_sat;
  logic [15:0] cb_next;
  logic [4:0]  cc_next;
  logic [10:0] vb_next;
  logic signed [11:0] conv;
  logic [11:0] full;

  assign in_ready = (state == S_IDLE);
  assign we = in_valid && in_ready &&
              (kind == jbhd_pkg::KindLoadDc || kind == jbhd_pkg::KindLoadAc);
  assign wentry = '{code: entry_code, length: entry_length, symbol: entry_symbol};
  assign raddr = {phase == PH_AC, idx[3:0]};

  jbhd_ram #(.Width(jbhd_pkg::EntryBits), .Depth(jbhd_pkg::MemDepth)) u_tab (
    .clk(clk), .we(we), .waddr({kind[0], entry_slot}), .wdata(wentry),
    .raddr(raddr), .rdata(rentry));

  always_comb begin
    lim = (phase == PH_AC) ? ac_used : dc_used;
    if (lim > 5'd16) lim = 5'd16;
    mag_sat = (rentry.symbol[3:0] > 4'd11) ? 4'd11 : rentry.symbol[3:0];
    cb_next = {code_bits[14:0], bit_value};
    cc_next = code_count + 5'd1;
    vb_next = {value_bits[9:0], bit_value};
    full = (12'd1 << cur_mag) - 12'd1;
    if (cur_mag == 4'd0) conv = '0;
    else if (vb_next[cur_mag - 4'd1]) conv = $signed({1'b0, vb_next} & full);
    else conv = $signed(({1'b0, vb_next} & full) - full);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; phase <= PH_DC; emode <= E_COEF;
      dc_used <= '0; ac_used <= '0; code_bits <= '0; code_count <= '0;
      mag_left <= '0; cur_mag <= '0; value_bits <= '0; run <= '0; pos <= '0;
      idx <= '0; out_valid <= 1'b0; pend_val <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == jbhd_pkg::RegDcUsed) dc_used <= cfg_data;
        else ac_used <= cfg_data;
      end
      case (state)
        S_IDLE: if (in_valid && kind == jbhd_pkg::KindBit) begin
          if (phase == PH_MAG) begin
            // gather magnitude bit
            if (mag_left <= 4'd1) begin
              mag_left <= '0; value_bits <= '0; cur_mag <= '0;
              pend_val <= conv; emode <= E_COEF;
              if (pos == 6'd0) run <= '0;
              phase <= PH_AC; state <= S_EMIT;
            end else begin
              value_bits <= vb_next; mag_left <= mag_left - 4'd1;
            end
          end else begin
            code_bits <= cb_next; code_count <= cc_next;
            idx <= '0; state <= S_READ;
          end
        end
        S_READ: begin
          if (idx >= lim) begin
            if (code_count >= 5'(jbhd_pkg::MaxCodeBits)) begin
              coeff_position <= pos; coeff_value <= '0;
              block_last <= 1'b1; code_error <= 1'b1; out_valid <= 1'b1;
              phase <= PH_DC; pos <= '0; code_bits <= '0; code_count <= '0;
              run <= '0; state <= S_WAIT;
            end else state <= S_IDLE;
          end else state <= S_CHECK;
        end
        S_CHECK: begin
          if (rentry.length == code_count && rentry.code == code_bits) begin
            code_bits <= '0; code_count <= '0;
            if (phase == PH_DC) begin
              if (mag_sat == 4'd0) begin
                run <= '0; pend_val <= '0; emode <= E_COEF;
                phase <= PH_AC; state <= S_EMIT;
              end else begin
                pos <= '0; cur_mag <= mag_sat; mag_left <= mag_sat;
                value_bits <= '0; phase <= PH_MAG; state <= S_IDLE;
              end
            end else if (rentry.symbol == 8'h00) begin
              run <= '0; emode <= E_EOB; pend_val <= '0; state <= S_EMIT;
            end else begin
              run <= rentry.symbol[7:4];
              if (mag_sat == 4'd0) begin
                pend_val <= '0; emode <= E_COEF; state <= S_EMIT;
              end else begin
                cur_mag <= mag_sat; mag_left <= mag_sat; value_bits <= '0;
                phase <= PH_MAG; state <= S_IDLE;
              end
            end
          end else begin
            idx <= idx + 5'd1; state <= S_READ;
          end
        end
        S_EMIT: begin
          coeff_position <= pos; code_error <= 1'b0; out_valid <= 1'b1;
          block_last <= (pos == 6'd63);
          if (emode == E_EOB) begin
            // hold EOB mode: fill zeros until the block ends
            coeff_value <= '0;
          end else if (run != 4'd0) begin
            coeff_value <= '0;
            run <= (pos == 6'd63) ? 4'd0 : run - 4'd1;
          end else begin
            coeff_value <= pend_val; emode <= E_ONE;
          end
          if (pos == 6'd63) begin
            pos <= '0; phase <= PH_DC;
          end else pos <= pos + 6'd1;
          state <= S_WAIT;
        end
        S_WAIT: if (out_ready) begin
          out_valid <= 1'b0;
          // advance: more beats unless the block ended or the item is done
          state <= (block_last || emode == E_ONE) ? S_IDLE : S_EMIT;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_emit_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |=> out_valid) else $error("emit without beat");
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && code_error) |-> block_last) else $error("error not last");
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken during output");
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && block_last && !code_error) |-> coeff_position == 6'd63)
    else $error("last off position 63");
endmodule
`default_nettype wire

@@ sv/jbhd_ram.sv @@
// Generic single-port-write, registered-read RAM.
`default_nettype none
module jbhd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
